// File: hdl/two_d_radix2_fft_macros.svh
// Assertion macros for the two-dimensional FFT block.
// Included by files that carry concurrent assertions; needs nothing else.
`ifndef TWO_D_RADIX2_FFT_MACROS_SVH
`define TWO_D_RADIX2_FFT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TDFFT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TDFFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tdfft_pkg.sv
// Shared types, constants and twiddle ROM functions for the 2-D FFT block.
// Used by every module of the block but tdfft_ram; depends on nothing.
`default_nettype none

package tdfft_pkg;

	localparam int LOG2_MAX_SIDE_DEF = 6;
	localparam int STORE_WIDTH_DEF   = 32;
	localparam int TWIDDLE_WIDTH_DEF = 16;
	localparam int SAMPLE_WIDTH      = 16;
	localparam int POINT_WIDTH       = 32;
	localparam int INDEX_WIDTH       = 12;
	localparam int CFG_DATA_WIDTH    = 3;

	// round(2*pi * 2^30)
	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam longint unsigned ONE_Q30    = 64'd1073741824;

	typedef enum logic [1:0] {
		OP_LOAD      = 2'd0,
		OP_TRANSFORM = 2'd1,
		OP_READ      = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_LOG2_WIDTH  = 2'd0,
		CFG_LOG2_HEIGHT = 2'd1,
		CFG_INVERSE     = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		op_t                            operation;
		logic [INDEX_WIDTH-1:0]         point_index;
		logic signed [SAMPLE_WIDTH-1:0] sample_real;
		logic signed [SAMPLE_WIDTH-1:0] sample_imag;
	} in_item_t;

	typedef struct packed {
		logic signed [POINT_WIDTH-1:0] point_real;
		logic signed [POINT_WIDTH-1:0] point_imag;
		logic [INDEX_WIDTH-1:0]        point_position;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_BF_RB,
		ST_BF_RA,
		ST_BF_M0,
		ST_BF_M1,
		ST_BF_M2,
		ST_BF_M3,
		ST_BF_SUM,
		ST_BF_WA,
		ST_BF_WB,
		ST_WB_RD,
		ST_WB_WR
	} st_t;

	// Controller to datapath
	typedef struct packed {
		logic host_load;
		logic host_read;
		logic out_load;
		logic start;
		logic elem_inc;
		logic line_inc;
		logic bf_init;
		logic pair_step;
		logic frame_rd_eng;
		logic frame_wr_eng;
		logic line_wr_load;
		logic line_wr_a;
		logic line_wr_b;
		logic line_rd_a;
		logic line_rd_b;
		logic line_rd_elem;
		logic tw_load;
		logic b_load;
		logic a_load;
		logic mul_imag;
		logic mul_sin;
		logic xr_load;
		logic xr_sub;
		logic xi_load;
		logic xi_add;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic elem_last;
		logic pair_last;
		logic stage_last;
		logic line_last;
		logic axis_col;
		logic bits_zero;
	} status_t;

	function automatic longint unsigned qmul30(input longint unsigned a,
			input longint unsigned b);
		return (a * b + 64'd536870912) >> 30;
	endfunction

	// Clamp a Q30 value to [0, 1], round half up to tw-1 fraction bits, saturate
	function automatic longint rom_round(input longint q, input int tw);
		longint r;
		longint maxv;
		longint qc;
		int     sh;
		sh   = 30 - (tw - 1);
		maxv = (64'sd1 <<< (tw - 1)) - 64'sd1;
		qc   = q;
		if (qc < 0)
			qc = 0;
		if (qc > longint'(ONE_Q30))
			qc = longint'(ONE_Q30);
		r = (qc + (64'sd1 <<< (sh - 1))) >>> sh;
		return (r > maxv) ? maxv : r;
	endfunction

	// Twiddle entry m of a table for sides of 2^l2; elaboration time only
	function automatic longint tw_value(input int m, input int l2, input int tw,
			input bit want_cos);
		bit                mirror;
		longint unsigned   mm;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   ts;
		longint unsigned   tc;
		longint            s;
		longint            c;
		mirror = (4 * m) > (1 << l2);
		mm     = mirror ? longint'((1 << (l2 - 1)) - m) : longint'(m);
		x      = (mm * TWO_PI_Q30) >> l2;
		x2     = qmul30(x, x);
		ts     = x;
		tc     = ONE_Q30;
		s      = longint'(x);
		c      = longint'(ONE_Q30);
		for (int n = 1; n <= 12; n++) begin
			unique case (n)
				1: begin ts = qmul30(ts, x2) / 6;   tc = qmul30(tc, x2) / 2;   end
				2: begin ts = qmul30(ts, x2) / 20;  tc = qmul30(tc, x2) / 12;  end
				3: begin ts = qmul30(ts, x2) / 42;  tc = qmul30(tc, x2) / 30;  end
				4: begin ts = qmul30(ts, x2) / 72;  tc = qmul30(tc, x2) / 56;  end
				5: begin ts = qmul30(ts, x2) / 110; tc = qmul30(tc, x2) / 90;  end
				6: begin ts = qmul30(ts, x2) / 156; tc = qmul30(tc, x2) / 132; end
				7: begin ts = qmul30(ts, x2) / 210; tc = qmul30(tc, x2) / 182; end
				8: begin ts = qmul30(ts, x2) / 272; tc = qmul30(tc, x2) / 240; end
				9: begin ts = qmul30(ts, x2) / 342; tc = qmul30(tc, x2) / 306; end
				10: begin ts = qmul30(ts, x2) / 420; tc = qmul30(tc, x2) / 380; end
				11: begin ts = qmul30(ts, x2) / 506; tc = qmul30(tc, x2) / 462; end
				12: begin ts = qmul30(ts, x2) / 600; tc = qmul30(tc, x2) / 552; end
				default: begin ts = 0; tc = 0; end
			endcase
			if ((n % 2) == 1) begin
				s = s - longint'(ts);
				c = c - longint'(tc);
			end else begin
				s = s + longint'(ts);
				c = c + longint'(tc);
			end
		end
		if (want_cos)
			return mirror ? -rom_round(c, tw) : rom_round(c, tw);
		return rom_round(s, tw);
	endfunction

endpackage

`default_nettype wire

// File: hdl/tdfft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module tdfft_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds when re is low
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/tdfft_datapath.sv
// Datapath of the 2-D FFT: frame and line memories, loop counters, twiddle
// ROM, shared multiplier and butterfly adders. Uses tdfft_pkg, tdfft_ram.
`default_nettype none

module tdfft_datapath import tdfft_pkg::*; #(
	parameter int LOG2_MAX_SIDE = LOG2_MAX_SIDE_DEF,
	parameter int STORE_WIDTH   = STORE_WIDTH_DEF,
	parameter int TWIDDLE_WIDTH = TWIDDLE_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cmd_t                      cmd,
	output status_t                        status,
	input  wire in_item_t                  item,
	input  wire logic [CFG_DATA_WIDTH-1:0] log2_width,
	input  wire logic [CFG_DATA_WIDTH-1:0] log2_height,
	input  wire logic                      inverse,
	output out_item_t                      result
);

	localparam int L         = LOG2_MAX_SIDE;
	localparam int MAX_SIDE  = 1 << L;
	localparam int AW        = 2 * L;
	localparam int FDEPTH    = 1 << AW;
	localparam int STW       = $clog2(L + 1);
	localparam int ROM_DEPTH = MAX_SIDE / 2;
	localparam int RW        = (L > 1) ? L - 1 : 1;
	localparam int SW        = STORE_WIDTH;
	localparam int TW        = TWIDDLE_WIDTH;
	localparam int PW        = SW + TW;
	localparam int XW        = SW + 3;
	localparam int DW        = 2 * SW;

	logic [STW-1:0] lw_e, lh_e, bits_e, stage_m1;
	logic           axis_q;
	logic [L-1:0]   line_q, elem_q, pair_q;
	logic [STW-1:0] stage_q;
	logic [L-1:0]   elem_max, line_max, pair_max;
	logic [L-1:0]   rev_full, elem_rev, bf_k, bf_a, bf_b, bf_m;
	logic [AW-1:0]  host_addr, eng_addr;

	logic          frame_we, frame_re;
	logic [AW-1:0] frame_waddr, frame_raddr;
	logic [DW-1:0] frame_wdata, frame_rd;
	logic          line_we, line_re;
	logic [L-1:0]  line_waddr, line_raddr;
	logic [DW-1:0] line_wdata, line_rd;

	logic signed [TW-1:0] rom_cos [ROM_DEPTH];
	logic signed [TW-1:0] rom_sin [ROM_DEPTH];
	logic signed [TW-1:0] c_q, t_q, opnd_w;
	logic signed [SW-1:0] a_re_q, a_im_q, b_re_q, b_im_q, opnd_v;
	logic signed [PW-1:0] prod_q;
	logic signed [PW:0]   rnd_sum;
	logic signed [SW+1:0] rnd;
	logic signed [XW-1:0] xr_q, xi_q;
	logic signed [XW:0]   sum_re, sum_im, dif_re, dif_im;
	logic [DW-1:0]        word_a, word_b, wb_word;
	logic signed [SW-1:0] wb_re, wb_im, rd_re, rd_im;
	logic [INDEX_WIDTH-1:0] rd_pos_q;
	logic signed [POINT_WIDTH-1:0] pt_re, pt_im;
	out_item_t            result_q;

	function automatic logic [SW-1:0] sat_store(input logic signed [XW:0] v);
		logic [XW-SW+1:0] upper;
		upper = v[XW:SW-1];
		if ((&upper) || !(|upper))
			return v[SW-1:0];
		return v[XW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
	endfunction

	// Side lengths clamped to the largest supported side
	always_comb begin
		lw_e = (int'(log2_width) > L) ? STW'(L) : STW'(log2_width);
		lh_e = (int'(log2_height) > L) ? STW'(L) : STW'(log2_height);
		bits_e = axis_q ? lh_e : lw_e;
		elem_max = ~({L{1'b1}} << bits_e);
		line_max = axis_q ? ~({L{1'b1}} << lw_e) : ~({L{1'b1}} << lh_e);
		pair_max = elem_max >> 1;
		stage_m1 = stage_q - STW'(1);
	end

	assign status.elem_last  = (elem_q == elem_max);
	assign status.pair_last  = (pair_q == pair_max);
	assign status.stage_last = (stage_q == bits_e);
	assign status.line_last  = (line_q == line_max);
	assign status.axis_col   = axis_q;
	assign status.bits_zero  = (bits_e == '0);

	// Loop counters: axis, line, element, butterfly pair and stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q  <= 1'b0;
			line_q  <= '0;
			elem_q  <= '0;
			pair_q  <= '0;
			stage_q <= '0;
		end else if (cmd.start) begin
			axis_q <= 1'b0;
			line_q <= '0;
			elem_q <= '0;
		end else begin
			if (cmd.elem_inc)
				elem_q <= status.elem_last ? '0 : elem_q + L'(1);
			if (cmd.line_inc) begin
				if (status.line_last) begin
					line_q <= '0;
					axis_q <= 1'b1;
				end else begin
					line_q <= line_q + L'(1);
				end
			end
			if (cmd.bf_init) begin
				stage_q <= STW'(1);
				pair_q  <= '0;
			end
			if (cmd.pair_step) begin
				if (status.pair_last) begin
					pair_q  <= '0;
					stage_q <= stage_q + STW'(1);
				end else begin
					pair_q <= pair_q + L'(1);
				end
			end
		end
	end

	// Addresses: host index wrapped to the frame, engine row or column walk
	always_comb begin
		host_addr = AW'(item.point_index) & ~({AW{1'b1}} << (AW'(lw_e) + AW'(lh_e)));
		if (axis_q)
			eng_addr = (AW'(elem_q) << lw_e) | AW'(line_q);
		else
			eng_addr = (AW'(line_q) << lw_e) | AW'(elem_q);
		for (int j = 0; j < L; j++)
			rev_full[j] = elem_q[L-1-j];
		elem_rev = rev_full >> (STW'(L) - bits_e);
		bf_k = pair_q & ~({L{1'b1}} << stage_m1);
		bf_a = ((pair_q >> stage_m1) << stage_q) | bf_k;
		bf_b = bf_a | (L'(1) << stage_m1);
		bf_m = bf_k << (STW'(L) - stage_q);
	end

	// Frame store: host load and read in idle, engine gather and scatter
	always_comb begin
		frame_we    = cmd.host_load | cmd.frame_wr_eng;
		frame_waddr = cmd.host_load ? host_addr : eng_addr;
		frame_wdata = cmd.host_load ?
			{SW'(item.sample_real), SW'(item.sample_imag)} : wb_word;
		frame_re    = cmd.host_read | cmd.frame_rd_eng;
		frame_raddr = cmd.host_read ? host_addr : eng_addr;
	end

	tdfft_ram #(.WIDTH(DW), .DEPTH(FDEPTH)) u_frame_ram (
		.clk   (clk),
		.we    (frame_we),
		.waddr (frame_waddr),
		.wdata (frame_wdata),
		.re    (frame_re),
		.raddr (frame_raddr),
		.rdata (frame_rd)
	);

	// Line buffer: bit-reversed fill, butterfly read-modify-write, drain
	always_comb begin
		line_we = cmd.line_wr_load | cmd.line_wr_a | cmd.line_wr_b;
		if (cmd.line_wr_load) begin
			line_waddr = elem_rev;
			line_wdata = frame_rd;
		end else if (cmd.line_wr_a) begin
			line_waddr = bf_a;
			line_wdata = word_a;
		end else begin
			line_waddr = bf_b;
			line_wdata = word_b;
		end
		line_re = cmd.line_rd_a | cmd.line_rd_b | cmd.line_rd_elem;
		if (cmd.line_rd_a)
			line_raddr = bf_a;
		else if (cmd.line_rd_b)
			line_raddr = bf_b;
		else
			line_raddr = elem_q;
	end

	tdfft_ram #(.WIDTH(DW), .DEPTH(MAX_SIDE)) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_waddr),
		.wdata (line_wdata),
		.re    (line_re),
		.raddr (line_raddr),
		.rdata (line_rd)
	);

	// Twiddle ROM, quarter-wave Taylor values fixed at elaboration
	for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
		localparam longint CV = tw_value(g, L, TW, 1'b1);
		localparam longint SV = tw_value(g, L, TW, 1'b0);
		assign rom_cos[g] = TW'(CV);
		assign rom_sin[g] = TW'(SV);
	end

	// Operand registers of one butterfly
	always_ff @(posedge clk) begin
		if (cmd.tw_load) begin
			c_q <= rom_cos[bf_m[RW-1:0]];
			t_q <= inverse ? rom_sin[bf_m[RW-1:0]] : -rom_sin[bf_m[RW-1:0]];
		end
		if (cmd.b_load) begin
			b_re_q <= line_rd[DW-1:SW];
			b_im_q <= line_rd[SW-1:0];
		end
		if (cmd.a_load) begin
			a_re_q <= line_rd[DW-1:SW];
			a_im_q <= line_rd[SW-1:0];
		end
	end

	// Shared multiplier, one real product per cycle, rounded half up
	assign opnd_v  = cmd.mul_imag ? b_im_q : b_re_q;
	assign opnd_w  = cmd.mul_sin ? t_q : c_q;
	assign rnd_sum = (PW+1)'(prod_q) + (PW+1)'(1 <<< (TW - 2));
	assign rnd     = $signed(rnd_sum[PW:TW-1]);

	always_ff @(posedge clk) begin
		prod_q <= opnd_v * opnd_w;
		if (cmd.xr_load)
			xr_q <= XW'(rnd);
		else if (cmd.xr_sub)
			xr_q <= xr_q - XW'(rnd);
		if (cmd.xi_load)
			xi_q <= XW'(rnd);
		else if (cmd.xi_add)
			xi_q <= xi_q + XW'(rnd);
	end

	// Butterfly outputs, saturated to the store width
	always_comb begin
		sum_re = (XW+1)'(a_re_q) + (XW+1)'(xr_q);
		sum_im = (XW+1)'(a_im_q) + (XW+1)'(xi_q);
		dif_re = (XW+1)'(a_re_q) - (XW+1)'(xr_q);
		dif_im = (XW+1)'(a_im_q) - (XW+1)'(xi_q);
		word_a = {sat_store(sum_re), sat_store(sum_im)};
		word_b = {sat_store(dif_re), sat_store(dif_im)};
	end

	// Drain: inverse scales by the axis length
	always_comb begin
		wb_re = $signed(line_rd[DW-1:SW]);
		wb_im = $signed(line_rd[SW-1:0]);
		if (inverse) begin
			wb_re = wb_re >>> bits_e;
			wb_im = wb_im >>> bits_e;
		end
		wb_word = {wb_re, wb_im};
	end

	// Read result: store value brought to the point width
	assign rd_re = $signed(frame_rd[DW-1:SW]);
	assign rd_im = $signed(frame_rd[SW-1:0]);

	if (SW > POINT_WIDTH) begin : g_rd_sat
		always_comb begin
			if ((&rd_re[SW-1:POINT_WIDTH-1]) || !(|rd_re[SW-1:POINT_WIDTH-1]))
				pt_re = rd_re[POINT_WIDTH-1:0];
			else
				pt_re = rd_re[SW-1] ? {1'b1, {(POINT_WIDTH-1){1'b0}}} :
					{1'b0, {(POINT_WIDTH-1){1'b1}}};
			if ((&rd_im[SW-1:POINT_WIDTH-1]) || !(|rd_im[SW-1:POINT_WIDTH-1]))
				pt_im = rd_im[POINT_WIDTH-1:0];
			else
				pt_im = rd_im[SW-1] ? {1'b1, {(POINT_WIDTH-1){1'b0}}} :
					{1'b0, {(POINT_WIDTH-1){1'b1}}};
		end
	end else begin : g_rd_ext
		assign pt_re = POINT_WIDTH'(rd_re);
		assign pt_im = POINT_WIDTH'(rd_im);
	end

	// Output register and the index echo of the read in flight
	always_ff @(posedge clk) begin
		if (cmd.host_read)
			rd_pos_q <= item.point_index;
		if (cmd.out_load) begin
			result_q.point_real     <= pt_re;
			result_q.point_imag     <= pt_im;
			result_q.point_position <= rd_pos_q;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

// File: hdl/tdfft_ctrl.sv
// Controller of the 2-D FFT: request handshakes and the sequencer that walks
// gather, butterfly and scatter steps. Uses tdfft_pkg.
`default_nettype none

module tdfft_ctrl import tdfft_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	input  wire op_t     item_op,
	output logic         item_stall,
	output logic         result_valid,
	input  wire logic    result_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	st_t  state_q, state_d;
	logic rd_pend_q;
	logic out_valid_q;
	logic out_free;
	logic accept;

	assign out_free   = !out_valid_q || !result_stall;
	assign item_stall = (state_q != ST_IDLE) || (rd_pend_q && !out_free);
	assign accept     = item_valid && !item_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept && (item_op == OP_TRANSFORM)) state_d = ST_LD_RD;
			ST_LD_RD:  state_d = ST_LD_WR;
			ST_LD_WR: begin
				if (!status.elem_last)
					state_d = ST_LD_RD;
				else if (status.bits_zero)
					state_d = ST_WB_RD;
				else
					state_d = ST_BF_RB;
			end
			ST_BF_RB:  state_d = ST_BF_RA;
			ST_BF_RA:  state_d = ST_BF_M0;
			ST_BF_M0:  state_d = ST_BF_M1;
			ST_BF_M1:  state_d = ST_BF_M2;
			ST_BF_M2:  state_d = ST_BF_M3;
			ST_BF_M3:  state_d = ST_BF_SUM;
			ST_BF_SUM: state_d = ST_BF_WA;
			ST_BF_WA:  state_d = ST_BF_WB;
			ST_BF_WB: begin
				if (status.pair_last && status.stage_last)
					state_d = ST_WB_RD;
				else
					state_d = ST_BF_RB;
			end
			ST_WB_RD:  state_d = ST_WB_WR;
			ST_WB_WR: begin
				if (!status.elem_last)
					state_d = ST_WB_RD;
				else if (status.line_last && status.axis_col)
					state_d = ST_IDLE;
				else
					state_d = ST_LD_RD;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.out_load = rd_pend_q && out_free;
		unique case (state_q)
			ST_IDLE: begin
				cmd.host_load = accept && (item_op == OP_LOAD);
				cmd.host_read = accept && (item_op == OP_READ);
				cmd.start     = accept && (item_op == OP_TRANSFORM);
			end
			ST_LD_RD:  cmd.frame_rd_eng = 1'b1;
			ST_LD_WR: begin
				cmd.line_wr_load = 1'b1;
				cmd.elem_inc     = 1'b1;
				cmd.bf_init      = status.elem_last;
			end
			ST_BF_RB: begin
				cmd.line_rd_b = 1'b1;
				cmd.tw_load   = 1'b1;
			end
			ST_BF_RA: begin
				cmd.line_rd_a = 1'b1;
				cmd.b_load    = 1'b1;
			end
			ST_BF_M0:  cmd.a_load = 1'b1;
			ST_BF_M1: begin
				cmd.mul_imag = 1'b1;
				cmd.mul_sin  = 1'b1;
				cmd.xr_load  = 1'b1;
			end
			ST_BF_M2: begin
				cmd.mul_sin = 1'b1;
				cmd.xr_sub  = 1'b1;
			end
			ST_BF_M3: begin
				cmd.mul_imag = 1'b1;
				cmd.xi_load  = 1'b1;
			end
			ST_BF_SUM: cmd.xi_add = 1'b1;
			ST_BF_WA:  cmd.line_wr_a = 1'b1;
			ST_BF_WB: begin
				cmd.line_wr_b = 1'b1;
				cmd.pair_step = 1'b1;
			end
			ST_WB_RD:  cmd.line_rd_elem = 1'b1;
			ST_WB_WR: begin
				cmd.frame_wr_eng = 1'b1;
				cmd.elem_inc     = 1'b1;
				cmd.line_inc     = status.elem_last;
			end
			default: ;
		endcase
	end

	// State, read in flight and output occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.host_read)
				rd_pend_q <= 1'b1;
			else if (cmd.out_load)
				rd_pend_q <= 1'b0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/two_d_radix2_fft.sv
// Top level of the 2-D radix-2 FFT: configuration registers, controller and
// datapath. Uses tdfft_pkg, tdfft_ctrl, tdfft_datapath and the macro header.
`default_nettype none
`include "two_d_radix2_fft_macros.svh"

// Holds one complex frame of up to 2^LOG2_MAX_SIDE by 2^LOG2_MAX_SIDE points.
// Load and read requests are taken one per clock while the block is idle and
// no read waits on a full output register; a read result passes the frame
// store's read register into an output register, and further requests are
// taken while it waits there. A transform request occupies the block until
// done: each line of n = 2^bits points is gathered in bit-reversed order, run
// through (n/2)*bits butterflies and scattered back, over every row and then
// every column. Each butterfly is paced by the line buffer (two reads, two
// writes) and the one shared multiplier forming the four real products. The
// frame store is not cleared at reset; read or transform only written points.
// Configuration writes are always ready and are meant for an idle block.
module two_d_radix2_fft import tdfft_pkg::*; #(
	parameter int LOG2_MAX_SIDE = LOG2_MAX_SIDE_DEF,
	parameter int STORE_WIDTH   = STORE_WIDTH_DEF,
	parameter int TWIDDLE_WIDTH = TWIDDLE_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_stall,
	input  wire in_item_t                  item,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output out_item_t                      result,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire cfg_reg_t                  cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data
);

	logic [CFG_DATA_WIDTH-1:0] log2_width_q, log2_height_q;
	logic                      inverse_q;
	cmd_t                      cmd;
	status_t                   status;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_width_q  <= CFG_DATA_WIDTH'(6);
			log2_height_q <= CFG_DATA_WIDTH'(6);
			inverse_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOG2_WIDTH:  log2_width_q  <= cfg_data;
				CFG_LOG2_HEIGHT: log2_height_q <= cfg_data;
				CFG_INVERSE:     inverse_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tdfft_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_op      (item.operation),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	tdfft_datapath #(
		.LOG2_MAX_SIDE (LOG2_MAX_SIDE),
		.STORE_WIDTH   (STORE_WIDTH),
		.TWIDDLE_WIDTH (TWIDDLE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.item        (item),
		.log2_width  (log2_width_q),
		.log2_height (log2_height_q),
		.inverse     (inverse_q),
		.result      (result)
	);

	// A read request is loaded into the output register next cycle or waits on a full one
	`TDFFT_ASSERT_NEXT(a_read_lands, clk, arst_n, cmd.host_read, cmd.out_load || (result_valid && result_stall), "read request neither delivered nor held")
	// Host requests never meet engine traffic on the frame store
	`TDFFT_ASSERT_IMPLY(a_frame_excl, clk, arst_n, cmd.host_load || cmd.host_read, !(cmd.frame_wr_eng || cmd.frame_rd_eng), "host and engine share frame store")
	// A loaded result is offered next cycle
	`TDFFT_ASSERT_NEXT(a_result_shown, clk, arst_n, cmd.out_load, result_valid, "loaded result not offered")

endmodule

`default_nettype wire
